// ----- hw/rtl/pve_pkg.sv -----
// Shared types and constants for the position/velocity estimator.
// Holds payload structs, the configuration set, controller commands and widths.
// No dependencies.
package pve_pkg;

  // Field widths
  localparam int AXES      = 3;
  localparam int AX_W      = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int POS_W     = 32;
  localparam int VAL_W     = 40;
  localparam int GAIN_W    = 16;
  localparam int COEF_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  // Internal arithmetic widths
  localparam int DIFF_W    = POS_W + 3;             // 3*p0 - 4*p1 + p2
  localparam int DPROD_W   = DIFF_W + GAIN_W + 1;   // difference times gain
  localparam int OP_W      = VAL_W + 1;             // sum of two taps
  localparam int SPLIT_W   = (OP_W + 1) / 2;        // low half of an operand
  localparam int HI_W      = OP_W - SPLIT_W;        // high half of an operand
  localparam int ACC_W     = OP_W + COEF_W + 4;     // five products, no overflow
  localparam int TAPS      = 5;
  localparam int MAC_STEPS = 2 * TAPS;
  localparam int STEP_W    = $clog2(MAC_STEPS);

  localparam int COEF_FRAC_BITS_DEF = 28;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A3   = 3'd5;

  // Register reset values
  localparam logic [GAIN_W-1:0]        DIFF_GAIN_RST = 16'd500;
  localparam logic signed [COEF_W-1:0] COEF_B0_RST   = 32'sd58948;
  localparam logic signed [COEF_W-1:0] COEF_B1_RST   = 32'sd176845;
  localparam logic signed [COEF_W-1:0] COEF_A1_RST   = -32'sd737875381;
  localparam logic signed [COEF_W-1:0] COEF_A2_RST   = 32'sd678658520;
  localparam logic signed [COEF_W-1:0] COEF_A3_RST   = -32'sd208735411;

  // Saturation bounds
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } pos_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
    logic signed [VAL_W-1:0] vel_z;
  } vel_req_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        diff_gain;
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
    logic signed [COEF_W-1:0] coef_a3;
  } pve_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              cap;    // capture an input request
    logic              diff;   // form difference times gain
    logic              sat;    // saturate raw rate, seed accumulator
    logic              mul;    // multiply one operand half
    logic              acc;    // accumulate the previous product
    logic              fin;    // round, saturate, update histories
    logic              push;   // load the output register
    logic [AX_W-1:0]   axis;
    logic [STEP_W-1:0] step;
  } pve_cmd_t;

endpackage

// ----- hw/rtl/pve_ctrl.sv -----
// Sequencing controller for the position/velocity estimator.
// Walks axes and multiply steps, drives datapath commands and the handshakes.
// Depends on pve_pkg.
module pve_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output pve_pkg::pve_cmd_t cmd
);
  import pve_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SAT,
    S_MAC,
    S_FIN,
    S_PUSH
  } state_t;

  state_t            state;
  logic [AX_W-1:0]   axis;
  logic [STEP_W-1:0] step;
  logic              push_ok;

  // Output register is free when empty or being drained this cycle
  assign push_ok  = !out_valid || !out_stall;
  // Hold off requests during reset and while an item is in progress
  assign in_stall = rst || (state != S_IDLE);

  // Decode commands from state
  always_comb begin
    cmd      = '0;
    cmd.axis = axis;
    cmd.step = step;
    cmd.cap  = (state == S_IDLE) && in_valid;
    cmd.diff = (state == S_DIFF);
    cmd.sat  = (state == S_SAT);
    cmd.mul  = (state == S_MAC);
    cmd.acc  = (state == S_MAC) && (step != '0);
    cmd.fin  = (state == S_FIN);
    cmd.push = (state == S_PUSH) && push_ok;
  end

  // Hold state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            axis  <= '0;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          state <= S_SAT;
        end
        S_SAT: begin
          step  <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          if (step == STEP_W'(MAC_STEPS - 1)) begin
            state <= S_FIN;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_FIN: begin
          if (axis == AX_W'(AXES - 1)) begin
            state <= S_PUSH;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_DIFF;
          end
        end
        S_PUSH: begin
          if (push_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/pve_datapath.sv -----
// Datapath of the position/velocity estimator: difference, gain, IIR taps.
// One shared split multiplier and a wide accumulator serve all axes in turn.
// Depends on pve_pkg; driven by pve_ctrl commands.
module pve_datapath #(
  parameter int COEF_FRAC_BITS = pve_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pve_pkg::pve_cmd_t cmd,
  input  pve_pkg::pve_cfg_t cfg,
  input  pve_pkg::pos_req_t in_data,
  output pve_pkg::vel_req_t out_data
);
  import pve_pkg::*;

  localparam logic [2:0] TERM_B0 = 3'd0;
  localparam logic [2:0] TERM_B1 = 3'd1;
  localparam logic [2:0] TERM_A1 = 3'd2;
  localparam logic [2:0] TERM_A2 = 3'd3;
  localparam logic [2:0] TERM_A3 = 3'd4;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  // Per-axis history
  logic signed [POS_W-1:0] pos_cur       [AXES];
  logic signed [POS_W-1:0] prev_pos      [AXES];
  logic signed [POS_W-1:0] prev_prev_pos [AXES];
  logic signed [VAL_W-1:0] rh1 [AXES];
  logic signed [VAL_W-1:0] rh2 [AXES];
  logic signed [VAL_W-1:0] rh3 [AXES];
  logic signed [VAL_W-1:0] oh1 [AXES];
  logic signed [VAL_W-1:0] oh2 [AXES];
  logic signed [VAL_W-1:0] oh3 [AXES];
  logic signed [VAL_W-1:0] res [AXES];

  // Working registers
  logic signed [DPROD_W-1:0] dprod;
  logic signed [VAL_W-1:0]   x0;
  logic signed [ACC_W-1:0]   prod;
  logic signed [ACC_W-1:0]   acc;

  // Combinational
  logic signed [DIFF_W-1:0]   d;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [DPROD_W-1:0]  dprod_next;
  logic signed [VAL_W-1:0]    x0_next;
  logic [2:0]                 term;
  logic                       half;
  logic signed [OP_W-1:0]     op;
  logic signed [COEF_W-1:0]   coef;
  logic signed [SPLIT_W:0]    op_lo;
  logic signed [HI_W-1:0]     op_hi;
  logic signed [SPLIT_W+COEF_W:0] pp_lo;
  logic signed [HI_W+COEF_W-1:0]  pp_hi;
  logic signed [ACC_W-1:0]    prod_next;
  logic signed [ACC_W-1:0]    sum;
  logic [ACC_W-COEF_FRAC_BITS-VAL_W:0] sum_top;
  logic signed [VAL_W-1:0]    y;
  logic [DPROD_W-VAL_W:0]     dprod_top;

  // Second-order backward difference times gain
  always_comb begin
    d = (DIFF_W'(pos_cur[cmd.axis]) <<< 1) + DIFF_W'(pos_cur[cmd.axis])
        - (DIFF_W'(prev_pos[cmd.axis]) <<< 2) + DIFF_W'(prev_prev_pos[cmd.axis]);
    gain_s     = {1'b0, cfg.diff_gain};
    dprod_next = DPROD_W'(d) * DPROD_W'(gain_s);
  end

  // Saturate the raw rate to the value range
  always_comb begin
    dprod_top = dprod[DPROD_W-1:VAL_W-1];
    if ((&dprod_top) || !(|dprod_top)) begin
      x0_next = dprod[VAL_W-1:0];
    end else begin
      x0_next = dprod[DPROD_W-1] ? VAL_MIN : VAL_MAX;
    end
  end

  // Select tap operand and coefficient, multiply one half
  always_comb begin
    term = 3'(cmd.step >> 1);
    half = cmd.step[0];
    case (term)
      TERM_B0: begin
        op   = OP_W'(x0) + OP_W'(rh3[cmd.axis]);
        coef = cfg.coef_b0;
      end
      TERM_B1: begin
        op   = OP_W'(rh1[cmd.axis]) + OP_W'(rh2[cmd.axis]);
        coef = cfg.coef_b1;
      end
      TERM_A1: begin
        op   = -OP_W'(oh1[cmd.axis]);
        coef = cfg.coef_a1;
      end
      TERM_A2: begin
        op   = -OP_W'(oh2[cmd.axis]);
        coef = cfg.coef_a2;
      end
      TERM_A3: begin
        op   = -OP_W'(oh3[cmd.axis]);
        coef = cfg.coef_a3;
      end
      default: begin
        op   = '0;
        coef = '0;
      end
    endcase
    op_lo = {1'b0, op[SPLIT_W-1:0]};
    op_hi = op[OP_W-1:SPLIT_W];
    pp_lo = (SPLIT_W+COEF_W+1)'(op_lo) * (SPLIT_W+COEF_W+1)'(coef);
    pp_hi = (HI_W+COEF_W)'(op_hi) * (HI_W+COEF_W)'(coef);
    if (half) begin
      prod_next = ACC_W'(pp_hi) <<< SPLIT_W;
    end else begin
      prod_next = ACC_W'(pp_lo);
    end
  end

  // Final sum, round by shift, saturate
  always_comb begin
    sum     = acc + prod;
    sum_top = sum[ACC_W-1:COEF_FRAC_BITS+VAL_W-1];
    if ((&sum_top) || !(|sum_top)) begin
      y = sum[COEF_FRAC_BITS+VAL_W-1:COEF_FRAC_BITS];
    end else begin
      y = sum[ACC_W-1] ? VAL_MIN : VAL_MAX;
    end
  end

  // Working registers and result buffer
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      pos_cur[0] <= in_data.pos_x;
      pos_cur[1] <= in_data.pos_y;
      pos_cur[2] <= in_data.pos_z;
    end
    if (cmd.diff) begin
      dprod <= dprod_next;
    end
    if (cmd.sat) begin
      x0  <= x0_next;
      acc <= ROUND_BIAS;
    end
    if (cmd.mul) begin
      prod <= prod_next;
    end
    if (cmd.acc) begin
      acc <= acc + prod;
    end
    if (cmd.fin) begin
      res[cmd.axis] <= y;
    end
    if (cmd.push) begin
      out_data.vel_x <= res[0];
      out_data.vel_y <= res[1];
      out_data.vel_z <= res[2];
    end
  end

  // Advance the per-axis histories
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        prev_pos[i]      <= '0;
        prev_prev_pos[i] <= '0;
        rh1[i] <= '0;
        rh2[i] <= '0;
        rh3[i] <= '0;
        oh1[i] <= '0;
        oh2[i] <= '0;
        oh3[i] <= '0;
      end
    end else if (cmd.fin) begin
      prev_prev_pos[cmd.axis] <= prev_pos[cmd.axis];
      prev_pos[cmd.axis]      <= pos_cur[cmd.axis];
      rh3[cmd.axis] <= rh2[cmd.axis];
      rh2[cmd.axis] <= rh1[cmd.axis];
      rh1[cmd.axis] <= x0;
      oh3[cmd.axis] <= oh2[cmd.axis];
      oh2[cmd.axis] <= oh1[cmd.axis];
      oh1[cmd.axis] <= y;
    end
  end

endmodule

// ----- hw/rtl/position_velocity_estimator.sv -----
// Each accepted position request is processed one axis at a time, and a new request is
// stalled until the velocity request is pushed, so throughput is set by the shared
// multiplier, which takes two passes per tap over five taps for each axis.
// The output register holds a result while the next request is accepted.
// Reset (rst, synchronous) restores register defaults and zeroes all histories.
// Depends on pve_pkg, pve_ctrl and pve_datapath.
module position_velocity_estimator #(
  parameter int COEF_FRAC_BITS = pve_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  pve_pkg::pos_req_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output pve_pkg::vel_req_t                 out_data,
  input  logic                              cfg_we,
  input  logic [pve_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pve_pkg::CFG_W-1:0]         cfg_data
);
  import pve_pkg::*;

  pve_cfg_t cfg;
  pve_cmd_t cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_gain <= DIFF_GAIN_RST;
      cfg.coef_b0   <= COEF_B0_RST;
      cfg.coef_b1   <= COEF_B1_RST;
      cfg.coef_a1   <= COEF_A1_RST;
      cfg.coef_a2   <= COEF_A2_RST;
      cfg.coef_a3   <= COEF_A3_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIFF_GAIN: cfg.diff_gain <= cfg_data[GAIN_W-1:0];
        REG_COEF_B0:   cfg.coef_b0   <= cfg_data[COEF_W-1:0];
        REG_COEF_B1:   cfg.coef_b1   <= cfg_data[COEF_W-1:0];
        REG_COEF_A1:   cfg.coef_a1   <= cfg_data[COEF_W-1:0];
        REG_COEF_A2:   cfg.coef_a2   <= cfg_data[COEF_W-1:0];
        REG_COEF_A3:   cfg.coef_a3   <= cfg_data[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pve_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pve_datapath #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- dv/velocity_checker.sv -----
// Checker for the position/velocity estimator. It tracks register writes,
// predicts each velocity request from the accepted position requests and compares.
// Depends on pve_pkg.
`timescale 1ns / 100ps

module velocity_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  pve_pkg::pos_req_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  pve_pkg::vel_req_t         out_data,
  input  logic                      cfg_we,
  input  logic [pve_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pve_pkg::CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        outstanding
);
  import pve_pkg::*;

  localparam int FRAC = COEF_FRAC_BITS_DEF;
  // Keep the log short when the block is badly broken
  localparam int SHOWN_LIMIT = 100;

  pve_cfg_t                shadow_cfg;
  logic signed [POS_W-1:0] last_pos  [AXES];
  logic signed [POS_W-1:0] older_pos [AXES];
  logic signed [VAL_W-1:0] rate_d1 [AXES];
  logic signed [VAL_W-1:0] rate_d2 [AXES];
  logic signed [VAL_W-1:0] rate_d3 [AXES];
  logic signed [VAL_W-1:0] vel_d1  [AXES];
  logic signed [VAL_W-1:0] vel_d2  [AXES];
  logic signed [VAL_W-1:0] vel_d3  [AXES];
  vel_req_t                expected_vel [$];
  int                      result_count;

  task automatic report_failure(input string msg);
    if (fail_count < SHOWN_LIMIT)
      $display("%t vel_check: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic signed [VAL_W-1:0] clamp_val(input logic signed [127:0] v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return v[VAL_W-1:0];
  endfunction

  // Advance the filter state by one position request and return the velocity
  function automatic vel_req_t predict_velocity(input pos_req_t p);
    logic signed [POS_W-1:0] now_pos [AXES];
    logic signed [VAL_W-1:0] vel [AXES];
    logic signed [VAL_W-1:0] raw;
    logic signed [127:0] wp0, wp1, wp2, diff, prod, acc;
    logic signed [127:0] wx0, wx1, wx2, wx3, wy1, wy2, wy3;
    logic signed [127:0] wb0, wb1, wa1, wa2, wa3;
    vel_req_t r;
    now_pos[0] = p.pos_x;
    now_pos[1] = p.pos_y;
    now_pos[2] = p.pos_z;
    wb0 = $signed(shadow_cfg.coef_b0);
    wb1 = $signed(shadow_cfg.coef_b1);
    wa1 = $signed(shadow_cfg.coef_a1);
    wa2 = $signed(shadow_cfg.coef_a2);
    wa3 = $signed(shadow_cfg.coef_a3);
    for (int a = 0; a < AXES; a++) begin
      // backward difference times gain, clamped to the value range
      wp0  = now_pos[a];
      wp1  = last_pos[a];
      wp2  = older_pos[a];
      diff = 3 * wp0 - 4 * wp1 + wp2;
      prod = diff * $signed({1'b0, shadow_cfg.diff_gain});
      raw  = clamp_val(prod);
      // exact IIR sum, round half up, then clamp
      wx0 = raw;
      wx1 = rate_d1[a];
      wx2 = rate_d2[a];
      wx3 = rate_d3[a];
      wy1 = vel_d1[a];
      wy2 = vel_d2[a];
      wy3 = vel_d3[a];
      acc = (wx0 + wx3) * wb0 + (wx1 + wx2) * wb1 - wy1 * wa1 - wy2 * wa2 - wy3 * wa3;
      acc = acc + (128'sd1 <<< (FRAC - 1));
      vel[a] = clamp_val(acc >>> FRAC);
      // shift histories
      older_pos[a] = last_pos[a];
      last_pos[a]  = now_pos[a];
      rate_d3[a]   = rate_d2[a];
      rate_d2[a]   = rate_d1[a];
      rate_d1[a]   = raw;
      vel_d3[a]    = vel_d2[a];
      vel_d2[a]    = vel_d1[a];
      vel_d1[a]    = vel[a];
    end
    r.vel_x = vel[0];
    r.vel_y = vel[1];
    r.vel_z = vel[2];
    return r;
  endfunction

  always @(posedge clk) begin
    vel_req_t want;
    if (rst) begin
      shadow_cfg = '{diff_gain: DIFF_GAIN_RST, coef_b0: COEF_B0_RST, coef_b1: COEF_B1_RST,
                     coef_a1: COEF_A1_RST, coef_a2: COEF_A2_RST, coef_a3: COEF_A3_RST};
      for (int a = 0; a < AXES; a++) begin
        last_pos[a]  = '0;
        older_pos[a] = '0;
        rate_d1[a]   = '0;
        rate_d2[a]   = '0;
        rate_d3[a]   = '0;
        vel_d1[a]    = '0;
        vel_d2[a]    = '0;
        vel_d3[a]    = '0;
      end
      expected_vel.delete();
      result_count = 0;
      outstanding  = 0;
    end else begin
      // track register writes; unused indexes drop
      if (cfg_we) begin
        case (cfg_index)
          REG_DIFF_GAIN: shadow_cfg.diff_gain = cfg_data[GAIN_W-1:0];
          REG_COEF_B0:   shadow_cfg.coef_b0   = cfg_data[COEF_W-1:0];
          REG_COEF_B1:   shadow_cfg.coef_b1   = cfg_data[COEF_W-1:0];
          REG_COEF_A1:   shadow_cfg.coef_a1   = cfg_data[COEF_W-1:0];
          REG_COEF_A2:   shadow_cfg.coef_a2   = cfg_data[COEF_W-1:0];
          REG_COEF_A3:   shadow_cfg.coef_a3   = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end

      // compare each velocity request with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_vel.size() == 0) begin
          report_failure($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = expected_vel.pop_front();
          if (out_data.vel_x !== want.vel_x)
            report_failure($sformatf("result %0d vel_x: got %0d expected %0d",
                                     result_count, out_data.vel_x, want.vel_x));
          if (out_data.vel_y !== want.vel_y)
            report_failure($sformatf("result %0d vel_y: got %0d expected %0d",
                                     result_count, out_data.vel_y, want.vel_y));
          if (out_data.vel_z !== want.vel_z)
            report_failure($sformatf("result %0d vel_z: got %0d expected %0d",
                                     result_count, out_data.vel_z, want.vel_z));
        end
        result_count++;
      end

      if (in_valid && !in_stall)
        expected_vel.push_back(predict_velocity(in_data));
      outstanding = expected_vel.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the estimator testbench: clock, reset, register settings and position
// stimulus with random gaps and output stalls. Depends on pve_pkg,
// position_velocity_estimator and velocity_checker.
`timescale 1ns / 100ps

module testbench;
  import pve_pkg::*;

  typedef enum int {
    SET_DEFAULTS,
    SET_EXTREME_FIR,
    SET_UNITY,
    SET_ZERO_GAIN,
    SET_UNSTABLE,
    SET_NEAR_DEFAULT,
    SET_RANDOM
  } coef_set_e;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd1 <<< COEF_FRAC_BITS_DEF;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int SETTLE_CYCLES = 50;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  pos_req_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  vel_req_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  int                   fail_count;
  int                   outstanding;
  bit                   steady    = 1'b0;
  longint               track_pos  [AXES];
  longint               track_rate [AXES];
  int                   accel_shift = 4;
  coef_set_e            phase_plan [PHASES] = '{SET_RANDOM, SET_NEAR_DEFAULT, SET_UNSTABLE,
                                                SET_ZERO_GAIN, SET_RANDOM, SET_EXTREME_FIR,
                                                SET_RANDOM, SET_DEFAULTS};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  position_velocity_estimator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  velocity_checker vel_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Mostly short gaps, a few long ones, none in steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic signed [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 9))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      3, 4, 5: return $urandom;
      default: return int'($urandom_range(0, 1 << 29)) - (1 << 28);
    endcase
  endfunction

  task automatic send_position(input pos_req_t p);
    bit taken;
    int gap;
    taken = 1'b0;
    in_data  <= p;
    in_valid <= 1'b1;
    // hold the request until an edge with stall low
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every velocity request, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input coef_set_e kind);
    logic [GAIN_W-1:0]        gain;
    logic signed [COEF_W-1:0] c [5];
    gain = DIFF_GAIN_RST;
    c = '{COEF_B0_RST, COEF_B1_RST, COEF_A1_RST, COEF_A2_RST, COEF_A3_RST};
    case (kind)
      SET_EXTREME_FIR: begin
        gain = '1;
        c = '{COEF_MAX, COEF_MIN, '0, '0, '0};
      end
      SET_UNITY: begin
        gain = 16'd1;
        c = '{COEF_ONE, '0, '0, '0, '0};
      end
      SET_ZERO_GAIN: gain = '0;
      SET_UNSTABLE: begin
        gain = GAIN_W'($urandom);
        c = '{random_coef(), random_coef(), COEF_MIN, COEF_MAX, COEF_MIN};
      end
      SET_NEAR_DEFAULT: begin
        gain = GAIN_W'($urandom_range(1, 2000));
        for (int i = 0; i < 5; i++)
          c[i] = c[i] + (int'($urandom_range(0, 8192)) - 4096);
      end
      SET_RANDOM: begin
        gain = GAIN_W'($urandom_range(1, 65535));
        for (int i = 0; i < 5; i++)
          c[i] = random_coef();
      end
      default: ;
    endcase
    wait_idle();
    // upper bits of the gain write are junk the block must drop
    write_reg(REG_DIFF_GAIN, {16'($urandom), gain});
    write_reg(REG_COEF_B0, c[0]);
    write_reg(REG_COEF_B1, c[1]);
    write_reg(REG_COEF_A1, c[2]);
    write_reg(REG_COEF_A2, c[3]);
    write_reg(REG_COEF_A3, c[4]);
    if (kind == SET_RANDOM) begin
      write_reg(REG_SPARE_6, $urandom);
      write_reg(REG_SPARE_7, $urandom);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly smooth trajectories, some jumps, extremes and holds
  task automatic next_position(output pos_req_t p);
    int r;
    longint v;
    r = $urandom_range(0, 99);
    for (int a = 0; a < AXES; a++) begin
      v = track_pos[a];
      if (r < 65) begin
        track_rate[a] += longint'($urandom_range(0, 2 << accel_shift))
                         - (longint'(1) << accel_shift);
        if (track_rate[a] > POS_MAX) track_rate[a] = POS_MAX;
        if (track_rate[a] < -longint'(POS_MAX)) track_rate[a] = -longint'(POS_MAX);
        v = track_pos[a] + track_rate[a];
        if (v > POS_MAX || v < POS_MIN) begin
          v = (v > POS_MAX) ? POS_MAX : POS_MIN;
          track_rate[a] = -track_rate[a];
        end
      end else if (r < 85) begin
        v = longint'(int'($urandom));
      end else if (r < 95) begin
        case ($urandom_range(0, 4))
          0:       v = POS_MAX;
          1:       v = POS_MIN;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      track_pos[a] = v;
    end
    p.pos_x = track_pos[0][POS_W-1:0];
    p.pos_y = track_pos[1][POS_W-1:0];
    p.pos_z = track_pos[2][POS_W-1:0];
  endtask

  // Output stalls: short bursts mostly, a few long ones, none when steady
  initial begin
    int len;
    forever begin
      if (steady) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(15, 90);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    pos_req_t p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset coefficients: zero, extremes, steps and a short ramp
    send_position('{0, 0, 0});
    send_position('{POS_MAX, POS_MAX, POS_MAX});
    send_position('{POS_MAX, POS_MAX, POS_MAX});
    send_position('{POS_MIN, POS_MIN, POS_MIN});
    send_position('{POS_MAX, POS_MIN, 0});
    send_position('{1, -1, 0});
    send_position('{-1, 1, POS_MAX});
    send_position('{POS_MIN, POS_MAX, -1});
    for (int k = 1; k <= 4; k++)
      send_position('{k * 1000, -k * 70000, k * k * 5});
    send_position('{0, 0, 0});
    send_position('{0, 0, 0});

    // full gain with extreme taps drives both saturations
    apply_setting(SET_EXTREME_FIR);
    send_position('{POS_MAX, POS_MIN, 0});
    send_position('{POS_MIN, POS_MAX, 0});
    send_position('{POS_MAX, POS_MIN, 1});
    send_position('{0, 0, 0});

    // unity pass-through exposes the rounding
    apply_setting(SET_UNITY);
    send_position('{3, -3, 7});
    send_position('{5, -8, 7});
    send_position('{0, 0, 0});

    for (int a = 0; a < AXES; a++) begin
      track_pos[a]  = 0;
      track_rate[a] = 0;
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(phase_plan[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0)
          steady = ($urandom_range(0, 3) == 0);
        if (i % 25 == 0)
          accel_shift = $urandom_range(0, 24);
        next_position(p);
        send_position(p);
      end
    end
    steady = 1'b0;

    wait_idle();
    if (fail_count == 0)
      $display("position_velocity_estimator verification clean");
    else
      $display("position_velocity_estimator verification failed");
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #8_000_000;
    $display("position_velocity_estimator verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pve_pkg.sv
hw/rtl/pve_ctrl.sv
hw/rtl/pve_datapath.sv
hw/rtl/position_velocity_estimator.sv
dv/velocity_checker.sv
dv/testbench.sv
